// File: rtl/core/rre_pkg.sv
// ============================================================================
// rre_pkg
// Shared types, constants and the control store of the breath rate estimator.
// ============================================================================
package rre_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_FAST_ALPHA     = 2'd0;
    localparam logic [1:0] CFG_PEAK_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_WINDOW_MS      = 2'd2;

    localparam logic [15:0] FAST_ALPHA_RST     = 16'd6554;
    localparam logic [15:0] PEAK_THRESHOLD_RST = 16'd334;
    localparam logic [19:0] WINDOW_MS_RST      = 20'd30000;

    // Baseline weight, about 0.01 in Q0.16
    localparam logic signed [17:0] BASE_WEIGHT = 18'sd655;
    // Twice the milliseconds per minute, for rounded division
    localparam logic signed [17:0] TWO_MS_PER_MIN = 18'sd120000;

    localparam logic [7:0]  RATE_MAX  = 8'hFF;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Quotient bits: eight rate bits plus one overflow bit
    localparam int unsigned QUO_W = 9;

    typedef logic [3:0] t_pc;

    localparam t_pc S_IDLE       = 4'd0;
    localparam t_pc S_PRIME      = 4'd1;
    localparam t_pc S_MUL_FAST   = 4'd2;
    localparam t_pc S_ADD_FAST   = 4'd3;
    localparam t_pc S_MUL_BASE   = 4'd4;
    localparam t_pc S_ADD_BASE   = 4'd5;
    localparam t_pc S_THRESH     = 4'd6;
    localparam t_pc S_WIN_CHK    = 4'd7;
    localparam t_pc S_ZERO_CHK   = 4'd8;
    localparam t_pc S_MUL_CNT    = 4'd9;
    localparam t_pc S_DIV_INIT   = 4'd10;
    localparam t_pc S_DIV_STEP   = 4'd11;
    localparam t_pc S_CLOSE_DIV  = 4'd12;
    localparam t_pc S_CLOSE_ZERO = 4'd13;
    localparam t_pc S_EMIT       = 4'd15;

    typedef enum logic [3:0] {
        U_NOP,
        U_LOAD,
        U_PRIME,
        U_MUL_FAST,
        U_ADD_FAST,
        U_MUL_BASE,
        U_ADD_BASE,
        U_THRESH,
        U_MUL_CNT,
        U_DIV_INIT,
        U_DIV_STEP,
        U_CLOSE_DIV,
        U_CLOSE_ZERO,
        U_EMIT
    } t_uop;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_NO_CLOSE,
        C_EL_ZERO,
        C_DIV_MORE,
        C_OUT_BUSY
    } t_ucond;

    typedef struct packed {
        t_uop   op;
        t_ucond cond;
        t_pc    target;
    } t_uword;

    // Control store: jump to target when cond holds, else step on.
    // The emit step sits last so that stepping on wraps to idle.
    function automatic t_uword rom(input t_pc pc);
        t_uword w;
        case (pc)
            S_IDLE:       w = '{U_LOAD,       C_NO_IN,    S_IDLE};
            S_PRIME:      w = '{U_PRIME,      C_NEVER,    S_IDLE};
            S_MUL_FAST:   w = '{U_MUL_FAST,   C_NEVER,    S_IDLE};
            S_ADD_FAST:   w = '{U_ADD_FAST,   C_NEVER,    S_IDLE};
            S_MUL_BASE:   w = '{U_MUL_BASE,   C_NEVER,    S_IDLE};
            S_ADD_BASE:   w = '{U_ADD_BASE,   C_NEVER,    S_IDLE};
            S_THRESH:     w = '{U_THRESH,     C_NEVER,    S_IDLE};
            S_WIN_CHK:    w = '{U_NOP,        C_NO_CLOSE, S_EMIT};
            S_ZERO_CHK:   w = '{U_NOP,        C_EL_ZERO,  S_CLOSE_ZERO};
            S_MUL_CNT:    w = '{U_MUL_CNT,    C_NEVER,    S_IDLE};
            S_DIV_INIT:   w = '{U_DIV_INIT,   C_NEVER,    S_IDLE};
            S_DIV_STEP:   w = '{U_DIV_STEP,   C_DIV_MORE, S_DIV_STEP};
            S_CLOSE_DIV:  w = '{U_CLOSE_DIV,  C_ALWAYS,   S_EMIT};
            S_CLOSE_ZERO: w = '{U_CLOSE_ZERO, C_ALWAYS,   S_EMIT};
            S_EMIT:       w = '{U_EMIT,       C_OUT_BUSY, S_EMIT};
            default:      w = '{U_NOP,        C_ALWAYS,   S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/rre_in_if.sv
// ============================================================================
// rre_in_if
// Sample channel: one accelerometer reading with its timestamp per item.
// ============================================================================
interface rre_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_z;
    logic [31:0]        time_ms;

    modport source (output valid, output accel_z, output time_ms, input ready);
    modport sink   (input valid, input accel_z, input time_ms, output ready);
endinterface

// File: rtl/core/rre_out_if.sv
// ============================================================================
// rre_out_if
// Result channel: rate, flags and deviation for each sample.
// ============================================================================
interface rre_out_if;
    logic               valid;
    logic               ready;
    logic [7:0]         breath_rate;
    logic               rate_updated;
    logic               breath_seen;
    logic signed [16:0] deviation;

    modport source (output valid, output breath_rate, output rate_updated,
                    output breath_seen, output deviation, input ready);
    modport sink   (input valid, input breath_rate, input rate_updated,
                    input breath_seen, input deviation, output ready);
endinterface

// File: rtl/core/respiratory_rate_estimator_unit.sv
// ============================================================================
// respiratory_rate_estimator_unit
// Breath rate from Z-axis acceleration: fast and baseline moving averages,
// threshold crossing count and a per-window rate, run by a small microprogram.
// ============================================================================
// One sample item is handled at a time. Its result is presented by the emit
// step, after which the sequencer returns to idle. A window close with zero
// elapsed time adds the zero check and its close step; a normal close
// adds the zero check, the count multiply, the divider set-up, nine
// compare-subtract steps of the rate division and the close step. All
// multiplications share one 33x18 multiplier, one step each. The result
// sits in an output register, so the next item may be accepted while it
// waits; the sequencer holds on its emit step only if the previous result
// has not yet been taken. Configuration takes effect from the next item
// only if the user writes it while idle; the block does not enforce this.
module respiratory_rate_estimator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_data,
    rre_in_if.sink      i_in,
    rre_out_if.source   o_out
);

    // Control and state
    rre_pkg::t_pc       r_pc;
    logic               r_primed;
    logic               r_above;
    logic [15:0]        r_count;
    logic [31:0]        r_wstart;
    logic [7:0]         r_rate;
    logic signed [31:0] r_fast;
    logic signed [31:0] r_base;
    logic [15:0]        r_alpha;
    logic [15:0]        r_thr;
    logic [19:0]        r_window;
    logic               r_out_valid;

    // Datapath
    logic signed [15:0] r_sample;
    logic [31:0]        r_now;
    logic signed [50:0] r_prod;
    logic [31:0]        r_elapsed;
    logic [33:0]        r_rem;
    logic [40:0]        r_dvs;
    logic [rre_pkg::QUO_W-1:0] r_quo;
    logic [3:0]         r_bit;
    logic               r_seen;
    logic               r_updated;
    logic signed [16:0] r_dev;

    // Output payload
    logic [7:0]         r_o_rate;
    logic               r_o_updated;
    logic               r_o_seen;
    logic signed [16:0] r_o_dev;

    rre_pkg::t_uword    uw;
    rre_pkg::t_pc       n_pc;
    logic               take;
    logic               out_free;
    logic signed [31:0] sample_q;
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] mul_p;
    logic signed [50:0] prod_rnd;
    logic [31:0]        ema_inc;
    logic signed [32:0] dev_q;
    logic signed [33:0] dev_rnd;
    logic [17:0]        dev_i;
    logic signed [16:0] dev_sat;
    logic               above;
    logic               crossing;
    logic               div_ge;

    assign uw       = rre_pkg::rom(r_pc);
    assign out_free = !r_out_valid || o_out.ready;
    assign sample_q = {r_sample, 16'h0000};

    always_comb begin
        case (uw.op)
            rre_pkg::U_MUL_FAST: begin
                mul_a = {sample_q[31], sample_q} - {r_fast[31], r_fast};
                mul_b = {2'b00, r_alpha};
            end
            rre_pkg::U_MUL_BASE: begin
                mul_a = {r_fast[31], r_fast} - {r_base[31], r_base};
                mul_b = rre_pkg::BASE_WEIGHT;
            end
            rre_pkg::U_MUL_CNT: begin
                mul_a = {17'h00000, r_count};
                mul_b = rre_pkg::TWO_MS_PER_MIN;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    // round half up, then only the low word matters for the wrapped sum
    assign prod_rnd = r_prod + 51'sd32768;
    assign ema_inc  = prod_rnd[47:16];

    assign dev_q   = {r_fast[31], r_fast} - {r_base[31], r_base};
    assign dev_rnd = {dev_q[32], dev_q} + 34'sd32768;
    assign dev_i   = dev_rnd[33:16];
    assign above   = dev_q > $signed({1'b0, r_thr, 16'h0000});
    assign crossing = above && !r_above;

    always_comb begin
        if (dev_i[17] != dev_i[16]) begin
            dev_sat = dev_i[17] ? 17'sh10000 : 17'sh0FFFF;
        end else begin
            dev_sat = dev_i[16:0];
        end
    end

    assign div_ge = {7'h00, r_rem} >= r_dvs;

    always_comb begin
        case (uw.cond)
            rre_pkg::C_NEVER:    take = 1'b0;
            rre_pkg::C_ALWAYS:   take = 1'b1;
            rre_pkg::C_NO_IN:    take = !i_in.valid;
            rre_pkg::C_NO_CLOSE: take = r_elapsed < {12'h000, r_window};
            rre_pkg::C_EL_ZERO:  take = r_elapsed == 32'h0;
            rre_pkg::C_DIV_MORE: take = r_bit != 4'd0;
            rre_pkg::C_OUT_BUSY: take = !out_free;
            default:             take = 1'b0;
        endcase
        n_pc = take ? uw.target : r_pc + 4'd1;
    end

    assign i_in.ready         = (r_pc == rre_pkg::S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.breath_rate  = r_o_rate;
    assign o_out.rate_updated = r_o_updated;
    assign o_out.breath_seen  = r_o_seen;
    assign o_out.deviation    = r_o_dev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= rre_pkg::S_IDLE;
            r_primed    <= 1'b0;
            r_above     <= 1'b0;
            r_count     <= '0;
            r_wstart    <= '0;
            r_rate      <= '0;
            r_fast      <= '0;
            r_base      <= '0;
            r_alpha     <= rre_pkg::FAST_ALPHA_RST;
            r_thr       <= rre_pkg::PEAK_THRESHOLD_RST;
            r_window    <= rre_pkg::WINDOW_MS_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rre_pkg::CFG_FAST_ALPHA:     r_alpha  <= i_cfg_data[15:0];
                    rre_pkg::CFG_PEAK_THRESHOLD: r_thr    <= i_cfg_data[15:0];
                    rre_pkg::CFG_WINDOW_MS:      r_window <= i_cfg_data;
                    default: ;
                endcase
            end

            case (uw.op)
                rre_pkg::U_PRIME: begin
                    if (!r_primed) begin
                        r_fast   <= sample_q;
                        r_base   <= sample_q;
                        r_wstart <= r_now;
                        r_primed <= 1'b1;
                    end
                end
                rre_pkg::U_ADD_FAST: r_fast <= r_fast + ema_inc;
                rre_pkg::U_ADD_BASE: r_base <= r_base + ema_inc;
                rre_pkg::U_THRESH: begin
                    r_above <= above;
                    if (crossing && r_count != rre_pkg::COUNT_MAX) begin
                        r_count <= r_count + 16'd1;
                    end
                end
                rre_pkg::U_CLOSE_DIV: begin
                    r_rate   <= r_quo[rre_pkg::QUO_W-1] ? rre_pkg::RATE_MAX : r_quo[7:0];
                    r_count  <= '0;
                    r_wstart <= r_now;
                end
                rre_pkg::U_CLOSE_ZERO: begin
                    r_rate   <= (r_count != 16'h0) ? rre_pkg::RATE_MAX : 8'h00;
                    r_count  <= '0;
                    r_wstart <= r_now;
                end
                default: ;
            endcase

            if (uw.op == rre_pkg::U_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (uw.op)
            rre_pkg::U_LOAD: begin
                if (i_in.valid) begin
                    r_sample <= i_in.accel_z;
                    r_now    <= i_in.time_ms;
                end
            end
            rre_pkg::U_MUL_FAST,
            rre_pkg::U_MUL_BASE,
            rre_pkg::U_MUL_CNT: r_prod <= mul_p;
            rre_pkg::U_THRESH: begin
                r_seen    <= crossing;
                r_updated <= 1'b0;
                r_elapsed <= r_now - r_wstart;
                r_dev     <= dev_sat;
            end
            rre_pkg::U_DIV_INIT: begin
                // count*120000 + elapsed over 2*elapsed, top divisor shifted by eight
                r_rem <= r_prod[33:0] + {2'b00, r_elapsed};
                r_dvs <= {r_elapsed, 9'h000};
                r_quo <= '0;
                r_bit <= 4'd8;
            end
            rre_pkg::U_DIV_STEP: begin
                if (div_ge) begin
                    r_rem <= r_rem - r_dvs[33:0];
                end
                r_quo <= {r_quo[rre_pkg::QUO_W-2:0], div_ge};
                r_dvs <= {1'b0, r_dvs[40:1]};
                r_bit <= r_bit - 4'd1;
            end
            rre_pkg::U_CLOSE_DIV,
            rre_pkg::U_CLOSE_ZERO: r_updated <= 1'b1;
            rre_pkg::U_EMIT: begin
                if (out_free) begin
                    r_o_rate    <= r_rate;
                    r_o_updated <= r_updated;
                    r_o_seen    <= r_seen;
                    r_o_dev     <= r_dev;
                end
            end
            default: ;
        endcase
    end

    // A new result only ever comes from the emit step
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_pc) == rre_pkg::S_EMIT)
        else $error("result raised outside emit step");

    // A held result keeps the sequencer on its emit step
    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == rre_pkg::S_EMIT && r_out_valid && !o_out.ready) |=>
        r_pc == rre_pkg::S_EMIT)
        else $error("emit step left while output busy");

    // Divide loop stays within its nine steps
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc == rre_pkg::S_DIV_STEP |-> r_bit <= 4'd8)
        else $error("divide step counter out of range");

    // A window close always clears the breath count
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.op == rre_pkg::U_CLOSE_DIV || uw.op == rre_pkg::U_CLOSE_ZERO) |=>
        r_count == 16'h0)
        else $error("breath count not cleared on window close");

endmodule

// File: tb/sv/tb_respiratory_rate_estimator_unit.sv
// ============================================================================
// tb_respiratory_rate_estimator_unit
// Checks the breath rate estimator against a cycle-free predictor of the fast
// and baseline averages, threshold crossings and per-window rate, using
// directed corner items followed by randomised breathing waveforms.
// ============================================================================
module tb_respiratory_rate_estimator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 5000;

    typedef struct packed {
        logic [7:0]         rate;
        logic               updated;
        logic               seen;
        logic signed [16:0] dev;
    } t_breath_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [19:0] i_cfg_data;

    rre_in_if  sample_ch ();
    rre_out_if result_ch ();

    respiratory_rate_estimator_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (sample_ch),
        .o_out      (result_ch)
    );

    // Predictor state and register copies
    logic [15:0] alpha_reg;
    logic [15:0] thresh_reg;
    logic [19:0] window_reg;
    int          fast_avg;
    int          base_avg;
    bit          primed_q;
    bit          above_q;
    int unsigned breaths;
    logic [31:0] win_start;
    logic [7:0]  rate_now;

    t_breath_result expected_results[$];
    int unsigned    mismatches;
    int             quiet_cycles;
    bit             steady_flow;
    logic [31:0]    clock_ms;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint half_up_q16(input longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic int ema_update(input int avg, input int target, input longint w);
        longint diff;
        longint sum;
        diff = longint'(target) - longint'(avg);
        sum  = longint'(avg) + half_up_q16(diff * w);
        return sum[31:0];
    endfunction

    function automatic t_breath_result predict_sample(input logic signed [15:0] accel,
                                                      input logic [31:0] now);
        t_breath_result r;
        int             sample_q;
        longint         dev_q;
        longint         dev_r;
        longint         quo;
        logic [31:0]    elapsed;
        bit             above;
        r = '0;
        sample_q = int'(accel) * 65536;
        if (!primed_q) begin
            fast_avg  = sample_q;
            base_avg  = sample_q;
            win_start = now;
            primed_q  = 1'b1;
        end
        fast_avg = ema_update(fast_avg, sample_q, longint'(alpha_reg));
        base_avg = ema_update(base_avg, fast_avg, longint'(rre_pkg::BASE_WEIGHT));
        dev_q = longint'(fast_avg) - longint'(base_avg);
        above = dev_q > (longint'(thresh_reg) * 65536);
        if (above && !above_q) begin
            r.seen = 1'b1;
            if (breaths < 65535) breaths++;
        end
        above_q = above;
        elapsed = now - win_start;
        if (elapsed >= 32'(window_reg)) begin
            if (elapsed == 0) begin
                rate_now = (breaths == 0) ? 8'd0 : rre_pkg::RATE_MAX;
            end else begin
                quo = (longint'(breaths) * 120000 + longint'(elapsed))
                      / (2 * longint'(elapsed));
                rate_now = (quo > 255) ? rre_pkg::RATE_MAX : quo[7:0];
            end
            breaths   = 0;
            win_start = now;
            r.updated = 1'b1;
        end
        dev_r = half_up_q16(dev_q);
        if (dev_r > 65535) dev_r = 65535;
        if (dev_r < -65536) dev_r = -65536;
        r.rate = rate_now;
        r.dev  = dev_r[16:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Channel handling
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic signed [15:0] accel, input logic [31:0] stamp);
        while (!steady_flow && $urandom_range(99) < 37) begin
            sample_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.accel_z <= accel;
        sample_ch.time_ms <= stamp;
        do @(posedge i_clk); while (!sample_ch.ready);
        expected_results.push_back(predict_sample(accel, stamp));
    endtask

    // Sender holds off until every outstanding result has been taken
    task automatic wait_all_results();
        sample_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic load_settings(input logic [15:0] alpha, input logic [15:0] thresh,
                                 input logic [19:0] window);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= rre_pkg::CFG_FAST_ALPHA;
        i_cfg_data <= {4'b0, alpha};
        @(posedge i_clk);
        i_cfg_idx  <= rre_pkg::CFG_PEAK_THRESHOLD;
        i_cfg_data <= {4'b0, thresh};
        @(posedge i_clk);
        i_cfg_idx  <= rre_pkg::CFG_WINDOW_MS;
        i_cfg_data <= window;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        alpha_reg  = alpha;
        thresh_reg = thresh;
        window_reg = window;
    endtask

    always @(posedge i_clk) begin
        result_ch.ready <= steady_flow || ($urandom_range(99) >= 37);
    end

    task automatic report_field(input string name, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_breath_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing expected, actual rate %0d dev %0d",
                         $time, result_ch.breath_rate, $signed(result_ch.deviation));
            end else begin
                want = expected_results.pop_front();
                report_field("breath_rate", want.rate, result_ch.breath_rate);
                report_field("rate_updated", want.updated, result_ch.rate_updated);
                report_field("breath_seen", want.seen, result_ch.breath_seen);
                report_field("deviation", $signed(want.dev), $signed(result_ch.deviation));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (sample_ch.valid && sample_ch.ready)
                || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_respiratory_rate_estimator_unit NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // First item primes both averages and the window; later stamps wrap past 2^32
    task automatic test_priming_and_wrap();
        send_sample(16'sd16384, 32'hFFFF_A000);
        send_sample(16'sd20000, 32'hFFFF_A014);
        send_sample(16'sd12000, 32'hFFFF_F000);
        send_sample(16'sd24000, 32'h0000_0100);
        send_sample(16'sd16384, 32'h0000_1530);
        send_sample(16'sd16000, 32'h0000_1544);
    endtask

    task automatic test_field_extremes();
        wait_all_results();
        load_settings(16'hFFFF, 16'd0, 20'd1);
        send_sample(16'sh7FFF, 32'd100);
        send_sample(16'sh8000, 32'd101);
        send_sample(16'sd0, 32'd0);
        send_sample(-16'sd1, 32'hFFFF_FFFF);
        send_sample(16'sh7FFF, 32'hFFFF_FFFF);
        send_sample(16'sh8000, 32'h5555_AAAA);
        send_sample(16'sh5555, 32'hAAAA_5555);
    endtask

    // Alpha zero freezes the fast average; zero window closes on zero elapsed time
    task automatic test_alpha_zero_and_zero_window();
        wait_all_results();
        load_settings(16'd0, 16'd0, 20'd0);
        send_sample(16'sd1000, 32'd500);
        send_sample(-16'sd20000, 32'd500);
        send_sample(16'sd30000, 32'd500);
        wait_all_results();
        load_settings(16'hFFFF, 16'd0, 20'd0);
        send_sample(16'sd30000, 32'd500);
        send_sample(-16'sd30000, 32'd500);
        send_sample(16'sd30000, 32'd501);
    endtask

    task automatic breathing_run(input int n_items, input int amplitude);
        int period;
        int offset;
        int phase;
        int ramp;
        int level;
        int jitter;
        logic [31:0] noise_stamp;
        period = $urandom_range(6, 60);
        offset = int'($urandom_range(0, 32000)) - 16000;
        jitter = amplitude / 8 + 1;
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(99) < 8) begin
                // noise: arbitrary sample, arbitrary or repeated stamp
                noise_stamp = $urandom_range(1) ? $urandom : clock_ms;
                if ($urandom_range(1)) clock_ms = noise_stamp;
                send_sample(16'($urandom), noise_stamp);
            end else begin
                phase = k % period;
                ramp  = (phase < period / 2) ? phase : period - phase;
                level = offset - amplitude + (4 * amplitude * ramp) / period
                        + int'($urandom_range(0, 2 * jitter)) - jitter;
                if (level > 32767) level = 32767;
                if (level < -32768) level = -32768;
                clock_ms = clock_ms + $urandom_range(0, 60);
                send_sample(level[15:0], clock_ms);
            end
        end
    endtask

    task automatic test_breathing_patterns();
        int amplitude;
        for (int p = 0; p < 7; p++) begin
            amplitude = $urandom_range(40, 20000);
            wait_all_results();
            case (p)
                0: load_settings(16'hFFFF, 16'hFFFF, 20'd600000);
                1: load_settings(16'd1, 16'd0, 20'd1);
                2: load_settings(rre_pkg::FAST_ALPHA_RST, rre_pkg::PEAK_THRESHOLD_RST,
                                 20'd2000);
                default: load_settings(16'($urandom_range(1000, 65535)),
                                       16'($urandom_range(0, amplitude / 2)),
                                       20'($urandom_range(100, 3000)));
            endcase
            breathing_run(110, amplitude);
        end
    endtask

    // No idling on either side, with one drain in the middle
    task automatic test_steady_stream();
        wait_all_results();
        load_settings(16'd20000, 16'd300, 20'd1500);
        steady_flow = 1'b1;
        breathing_run(50, 3000);
        wait_all_results();
        breathing_run(60, 6000);
        steady_flow = 1'b0;
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= rre_pkg::CFG_FAST_ALPHA;
        i_cfg_data        <= '0;
        sample_ch.valid   <= 1'b0;
        sample_ch.accel_z <= '0;
        sample_ch.time_ms <= '0;
        alpha_reg    = rre_pkg::FAST_ALPHA_RST;
        thresh_reg   = rre_pkg::PEAK_THRESHOLD_RST;
        window_reg   = rre_pkg::WINDOW_MS_RST;
        fast_avg     = 0;
        base_avg     = 0;
        primed_q     = 1'b0;
        above_q      = 1'b0;
        breaths      = 0;
        win_start    = '0;
        rate_now     = '0;
        steady_flow  = 1'b0;
        clock_ms     = $urandom;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_priming_and_wrap();
        test_field_extremes();
        test_alpha_zero_and_zero_window();
        test_breathing_patterns();
        test_steady_stream();

        wait_all_results();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_respiratory_rate_estimator_unit OK");
        end else begin
            $display("tb_respiratory_rate_estimator_unit NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/rre_pkg.sv
rtl/core/rre_in_if.sv
rtl/core/rre_out_if.sv
rtl/core/respiratory_rate_estimator_unit.sv
tb/sv/tb_respiratory_rate_estimator_unit.sv
